### sv/chist_pkg.sv
// Shared types and constants for the 64-bin color histogram.
`timescale 1ns / 1ps

package chist_pkg;

   localparam int NUM_BINS  = 64;
   localparam int BIN_W     = 6;
   localparam int CNT_W     = 25;
   localparam int COORD_W   = 12;
   localparam int DIM_W     = 13;
   localparam int COLOR_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(NUM_BINS - 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_HEIGHT = 2'd3;

   typedef struct packed {
      logic             en;
      logic [BIN_W-1:0] addr;
      logic [CNT_W-1:0] data;
   } mem_wr_type;

   typedef enum logic [1:0] {
      RO_IDLE,
      RO_SWEEP,
      RO_FLUSH
   } ro_state_type;

endpackage

### sv/color_histogram_64bin_unit.sv
// Top level of the 64-bin RGB color histogram over a configurable window.
`timescale 1ns / 1ps

// Pixels are taken one per cycle while busy is low: each request is counted into
// one of 64 bins (top two bits of red, green and blue) when its coordinates fall
// inside the configured window. The counts live in a 64-entry RAM; the
// read-increment-write loop through that RAM is overlapped, so back-to-back
// requests to the same bin are forwarded. A request with frame_end set raises
// busy, and the 64 bins are read out in order, one strobe per cycle on
// rsp_valid, with rsp_last_bin on bin 63, and each bin is cleared as it goes
// out. The receiver cannot stall the readout, so it must take a result in every
// strobed cycle. After reset all bins read as zero at once. The user must write
// configuration through the csr_ port only while the block is idle; the block itself does not enforce this.

module color_histogram_64bin_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [chist_pkg::COORD_W-1:0]     req_pixel_x,
   input  logic [chist_pkg::COORD_W-1:0]     req_pixel_y,
   input  logic [chist_pkg::COLOR_W-1:0]     req_red,
   input  logic [chist_pkg::COLOR_W-1:0]     req_green,
   input  logic [chist_pkg::COLOR_W-1:0]     req_blue,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   output logic [chist_pkg::BIN_W-1:0]       rsp_bin_index,
   output logic [chist_pkg::CNT_W-1:0]       rsp_bin_count,
   output logic                              rsp_last_bin,
   input  logic                              csr_wr_en,
   input  logic [chist_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [chist_pkg::DIM_W-1:0]       csr_wr_data
);

   logic [chist_pkg::COORD_W-1:0]  rect_x_ff;
   logic [chist_pkg::COORD_W-1:0]  rect_y_ff;
   logic [chist_pkg::DIM_W-1:0]    rect_width_ff;
   logic [chist_pkg::DIM_W-1:0]    rect_height_ff;

   logic                           accept;
   logic                           frame_done;
   logic                           sweep_rd;
   logic [chist_pkg::BIN_W-1:0]    cnt_rd_bin;
   logic [chist_pkg::BIN_W-1:0]    ro_rd_bin;
   logic [chist_pkg::BIN_W-1:0]    rd_addr;
   chist_pkg::mem_wr_type          cnt_wr;
   chist_pkg::mem_wr_type          ro_wr;
   chist_pkg::mem_wr_type          wr;
   logic [chist_pkg::CNT_W-1:0]    ram_q;
   logic [chist_pkg::CNT_W-1:0]    rd_count;

   logic [chist_pkg::NUM_BINS-1:0] vld_ff;
   logic                           rd_vld_ff;
   logic                           fwd_hit_ff;
   logic [chist_pkg::CNT_W-1:0]    fwd_data_ff;

   assign accept     = start && !busy;
   assign frame_done = accept && req_frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff      <= '0;
         rect_y_ff      <= '0;
         rect_width_ff  <= '0;
         rect_height_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            chist_pkg::CSR_RECT_X:      rect_x_ff      <= csr_wr_data[chist_pkg::COORD_W-1:0];
            chist_pkg::CSR_RECT_Y:      rect_y_ff      <= csr_wr_data[chist_pkg::COORD_W-1:0];
            chist_pkg::CSR_RECT_WIDTH:  rect_width_ff  <= csr_wr_data;
            chist_pkg::CSR_RECT_HEIGHT: rect_height_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   chist_counter u_counter (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .rect_x      (rect_x_ff),
      .rect_y      (rect_y_ff),
      .rect_width  (rect_width_ff),
      .rect_height (rect_height_ff),
      .rd_count    (rd_count),
      .rd_bin      (cnt_rd_bin),
      .wr          (cnt_wr)
   );

   chist_readout u_readout (
      .clock         (clock),
      .reset         (reset),
      .frame_done    (frame_done),
      .rd_count      (rd_count),
      .busy          (busy),
      .sweep_rd      (sweep_rd),
      .rd_bin        (ro_rd_bin),
      .wr            (ro_wr),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_count (rsp_bin_count),
      .rsp_last_bin  (rsp_last_bin)
   );

   // The pixel pipeline and the readout never write in the same cycle.
   assign wr      = ro_wr.en ? ro_wr : cnt_wr;
   assign rd_addr = sweep_rd ? ro_rd_bin : cnt_rd_bin;

   chist_ram #(
      .WIDTH (chist_pkg::CNT_W),
      .DEPTH (chist_pkg::NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
      end
   end

   // A write landing on the same edge as the read of that entry is not seen by
   // the RAM read, so its data is carried over.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= wr.en && (wr.addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr.data;
   end

   assign rd_count = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? ram_q : '0);

endmodule

### sv/chist_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module chist_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/chist_counter.sv
// Window test, bin selection and saturating increment of one pixel.
`timescale 1ns / 1ps

module chist_counter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [chist_pkg::COORD_W-1:0]    pixel_x,
   input  logic [chist_pkg::COORD_W-1:0]    pixel_y,
   input  logic [chist_pkg::COLOR_W-1:0]    red,
   input  logic [chist_pkg::COLOR_W-1:0]    green,
   input  logic [chist_pkg::COLOR_W-1:0]    blue,
   input  logic [chist_pkg::COORD_W-1:0]    rect_x,
   input  logic [chist_pkg::COORD_W-1:0]    rect_y,
   input  logic [chist_pkg::DIM_W-1:0]      rect_width,
   input  logic [chist_pkg::DIM_W-1:0]      rect_height,
   input  logic [chist_pkg::CNT_W-1:0]      rd_count,
   output logic [chist_pkg::BIN_W-1:0]      rd_bin,
   output chist_pkg::mem_wr_type            wr
);

   logic [chist_pkg::DIM_W:0]   x_end;
   logic [chist_pkg::DIM_W:0]   y_end;
   logic                        in_window;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic [chist_pkg::BIN_W-1:0] s1_bin_ff;

   // Window ends are formed one bit wider so they never wrap.
   assign x_end = {2'b00, rect_x} + {1'b0, rect_width};
   assign y_end = {2'b00, rect_y} + {1'b0, rect_height};

   assign in_window = (pixel_x >= rect_x) && ({2'b00, pixel_x} < x_end) &&
                      (pixel_y >= rect_y) && ({2'b00, pixel_y} < y_end);

   assign rd_bin = {red[7:6], green[7:6], blue[7:6]};

   assign s1_valid_in = accept && in_window;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bin_ff <= rd_bin;
   end

   always_comb begin
      wr.en   = s1_valid_ff;
      wr.addr = s1_bin_ff;
      wr.data = (rd_count == chist_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1;
   end

endmodule

### sv/chist_readout.sv
// Frame-end sequencer: sweeps all bins out in order and clears each one.
`timescale 1ns / 1ps

module chist_readout (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        frame_done,
   input  logic [chist_pkg::CNT_W-1:0] rd_count,
   output logic                        busy,
   output logic                        sweep_rd,
   output logic [chist_pkg::BIN_W-1:0] rd_bin,
   output chist_pkg::mem_wr_type       wr,
   output logic                        rsp_valid,
   output logic [chist_pkg::BIN_W-1:0] rsp_bin_index,
   output logic [chist_pkg::CNT_W-1:0] rsp_bin_count,
   output logic                        rsp_last_bin
);

   chist_pkg::ro_state_type     state_ff;
   chist_pkg::ro_state_type     state_in;
   logic [chist_pkg::BIN_W-1:0] idx_ff;
   logic [chist_pkg::BIN_W-1:0] idx_in;
   logic                        out_valid_ff;
   logic [chist_pkg::BIN_W-1:0] out_idx_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chist_pkg::RO_IDLE: begin
            if (frame_done) begin
               state_in = chist_pkg::RO_SWEEP;
            end
         end
         chist_pkg::RO_SWEEP: begin
            if (idx_ff == chist_pkg::LAST_BIN) begin
               state_in = chist_pkg::RO_FLUSH;
            end
         end
         chist_pkg::RO_FLUSH: begin
            state_in = chist_pkg::RO_IDLE;
         end
         default: begin
            state_in = chist_pkg::RO_IDLE;
         end
      endcase
   end

   always_comb begin
      busy     = 1'b1;
      sweep_rd = 1'b0;
      idx_in   = idx_ff;
      case (state_ff)
         chist_pkg::RO_IDLE: begin
            busy   = 1'b0;
            idx_in = '0;
         end
         chist_pkg::RO_SWEEP: begin
            sweep_rd = 1'b1;
            idx_in   = idx_ff + 1'b1;
         end
         chist_pkg::RO_FLUSH: begin
            idx_in = '0;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chist_pkg::RO_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= sweep_rd;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff <= idx_ff;
   end

   assign rd_bin = idx_ff;

   // Each bin is zeroed in the cycle its count is presented.
   always_comb begin
      wr.en   = out_valid_ff;
      wr.addr = out_idx_ff;
      wr.data = '0;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_bin_index = out_idx_ff;
   assign rsp_bin_count = rd_count;
   assign rsp_last_bin  = out_valid_ff && (out_idx_ff == chist_pkg::LAST_BIN);

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the 64-bin color histogram: directed table, then random frames.
`timescale 1ns / 1ps

module tb;
   import chist_pkg::*;

   localparam int RANDOM_ITEMS  = 380;
   localparam int DRAIN_LIMIT   = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int FULL_DIM      = 4096;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               frame_end;
   } pixel_t;

   typedef struct {
      logic [BIN_W-1:0] index;
      logic [CNT_W-1:0] count;
      logic             last;
   } bin_readout_t;

   // One directed request. A window index of -1 keeps the current window; a typed row
   // carries its readout as one bin with a given count and every other bin at zero.
   typedef struct {
      int win;
      int x;
      int y;
      int red;
      int green;
      int blue;
      bit fe;
      bit typed;
      int hot_bin;
      int hot_cnt;
   } probe_row_t;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [COORD_W-1:0]   req_pixel_x;
   logic [COORD_W-1:0]   req_pixel_y;
   logic [COLOR_W-1:0]   req_red;
   logic [COLOR_W-1:0]   req_green;
   logic [COLOR_W-1:0]   req_blue;
   logic                 req_frame_end;
   logic                 rsp_valid;
   logic [BIN_W-1:0]     rsp_bin_index;
   logic [CNT_W-1:0]     rsp_bin_count;
   logic                 rsp_last_bin;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wr_data;

   // Histogram predictor state.
   logic [COORD_W-1:0]   win_x;
   logic [COORD_W-1:0]   win_y;
   logic [DIM_W-1:0]     win_w;
   logic [DIM_W-1:0]     win_h;
   logic [CNT_W-1:0]     bin_tally [NUM_BINS];

   bin_readout_t         expected_bins [$];
   int                   n_errors;

   probe_row_t           probes [25];
   int                   win_tab [5][4];

   color_histogram_64bin_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_frame_end (req_frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_count (rsp_bin_count),
      .rsp_last_bin  (rsp_last_bin),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Appends one expected bin to the end of the expected queue.
   function automatic void queue_bin(input int k, input logic [CNT_W-1:0] count);
      bin_readout_t item;
      item.index = BIN_W'(k);
      item.count = count;
      item.last  = (k == NUM_BINS - 1);
      expected_bins.insert(expected_bins.size(), item);
   endfunction

   // Counts one accepted pixel; on the frame's last pixel it queues the 64-bin readout
   // (unless the caller supplies its own) and clears the bins.
   function automatic void tally_pixel(input pixel_t p, input bit emit);
      logic [BIN_W-1:0] b;
      bit               in_x;
      bit               in_y;
      b = {p.red[7:6], p.green[7:6], p.blue[7:6]};
      in_x = int'(p.x) >= int'(win_x) && int'(p.x) < int'(win_x) + int'(win_w);
      in_y = int'(p.y) >= int'(win_y) && int'(p.y) < int'(win_y) + int'(win_h);
      if (in_x && in_y && bin_tally[b] != COUNT_MAX)
         bin_tally[b] = bin_tally[b] + 1'b1;
      if (p.frame_end) begin
         for (int k = 0; k < NUM_BINS; k++) begin
            if (emit)
               queue_bin(k, bin_tally[k]);
            bin_tally[k] = '0;
         end
      end
   endfunction

   task automatic send_pixel(input pixel_t p, input int gap, input bit typed = 0,
                             input int hot_bin = 0, input int hot_cnt = 0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_pixel_x   <= p.x;
      req_pixel_y   <= p.y;
      req_red       <= p.red;
      req_green     <= p.green;
      req_blue      <= p.blue;
      req_frame_end <= p.frame_end;
      do @(posedge clock); while (busy);
      if (typed && p.frame_end) begin
         for (int k = 0; k < NUM_BINS; k++)
            queue_bin(k, (k == hot_bin) ? CNT_W'(hot_cnt) : '0);
         tally_pixel(p, 1'b0);
      end else begin
         tally_pixel(p, 1'b1);
      end
   endtask

   // Holds requests off until every queued bin has come back, then lets the
   // count pipeline settle.
   task automatic wait_idle();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (expected_bins.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_bins.size() != 0) begin
         $error("%0d expected bins never arrived", expected_bins.size());
         n_errors++;
         expected_bins.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The spare top data bit on the 12-bit registers is set at random; it must be dropped.
   task automatic set_window(input int x, input int y, input int w, input int h);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_RECT_X;
      csr_wr_data <= {1'($urandom_range(0, 1)), 12'(x)};
      @(posedge clock);
      csr_index   <= CSR_RECT_Y;
      csr_wr_data <= {1'($urandom_range(0, 1)), 12'(y)};
      @(posedge clock);
      csr_index   <= CSR_RECT_WIDTH;
      csr_wr_data <= DIM_W'(w);
      @(posedge clock);
      csr_index   <= CSR_RECT_HEIGHT;
      csr_wr_data <= DIM_W'(h);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      win_x = COORD_W'(x);
      win_y = COORD_W'(y);
      win_w = DIM_W'(w);
      win_h = DIM_W'(h);
   endtask

   always @(posedge clock) begin
      bin_readout_t want;
      if (!reset && rsp_valid) begin
         if (expected_bins.size() == 0) begin
            $error("result with no request pending: bin_index %0d", rsp_bin_index);
            n_errors++;
         end else begin
            want = expected_bins.pop_front();
            if (rsp_bin_index !== want.index) begin
               $error("bin_index: expected %0d, actual %0d", want.index, rsp_bin_index);
               n_errors++;
            end
            if (rsp_bin_count !== want.count) begin
               $error("bin_count: expected %0d, actual %0d", want.count, rsp_bin_count);
               n_errors++;
            end
            if (rsp_last_bin !== want.last) begin
               $error("last_bin: expected %0d, actual %0d", want.last, rsp_last_bin);
               n_errors++;
            end
         end
      end
   end

   initial begin
      pixel_t      p;
      probe_row_t  r;
      int          n_sent;
      int          fw;
      int          fh;
      int          ox;
      int          oy;
      int          jit_x;
      int          jit_y;
      bit          use_palette;
      bit          no_gaps;
      logic [23:0] palette [3];
      logic [23:0] c;

      n_errors      = 0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_pixel_x   <= '0;
      req_pixel_y   <= '0;
      req_red       <= '0;
      req_green     <= '0;
      req_blue      <= '0;
      req_frame_end <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_RECT_X;
      csr_wr_data   <= '0;
      win_x = '0;
      win_y = '0;
      win_w = '0;
      win_h = '0;
      for (int k = 0; k < NUM_BINS; k++)
         bin_tally[k] = '0;

      win_tab = '{
         '{0, 0, FULL_DIM, FULL_DIM},       // whole image
         '{4095, 4095, FULL_DIM, FULL_DIM}, // runs past the image edge
         '{10, 20, 0, FULL_DIM},            // empty: zero width
         '{10, 20, FULL_DIM, 0},            // empty: zero height
         '{10, 20, 2, 3}                    // tiny window for the boundary checks
      };
      probes = '{
         // Reset window is empty, so the first readout is all zero.
         '{-1, 0, 0, 255, 255, 255, 1, 1, 0, 0},
         '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{-1, 4095, 4095, 255, 255, 255, 0, 0, 0, 0},
         '{-1, 5, 7, 8'h40, 8'h80, 8'hC0, 0, 0, 0, 0},
         '{-1, 100, 200, 8'hBF, 8'h7F, 8'h3F, 0, 0, 0, 0},
         '{-1, 1, 1, 255, 0, 0, 1, 0, 0, 0},
         // Only the corner pixel lies inside a window that hangs off the edge.
         '{1, 4094, 4095, 255, 255, 255, 0, 0, 0, 0},
         '{-1, 4095, 4094, 255, 255, 255, 0, 0, 0, 0},
         '{-1, 4095, 4095, 8'hC0, 8'h40, 8'h00, 1, 1, 52, 1},
         '{2, 10, 20, 128, 128, 128, 1, 1, 0, 0},
         '{3, 10, 20, 128, 128, 128, 1, 1, 0, 0},
         // One step outside each side of the tiny window, plus three inside.
         '{4, 9, 20, 0, 0, 0, 0, 0, 0, 0},
         '{-1, 10, 20, 0, 0, 0, 0, 0, 0, 0},
         '{-1, 11, 22, 0, 0, 0, 0, 0, 0, 0},
         '{-1, 12, 22, 0, 0, 0, 0, 0, 0, 0},
         '{-1, 11, 23, 0, 0, 0, 0, 0, 0, 0},
         '{-1, 10, 19, 0, 0, 0, 0, 0, 0, 0},
         '{-1, 10, 21, 0, 0, 0, 1, 1, 0, 3},
         // Repeated hits on one bin exercise the read-modify-write forwarding.
         '{0, 0, 0, 8'h3F, 8'h3F, 8'h3F, 0, 0, 0, 0},
         '{-1, 1, 0, 8'h3F, 8'h3F, 8'h3F, 0, 0, 0, 0},
         '{-1, 2, 0, 8'h00, 8'h20, 8'h10, 0, 0, 0, 0},
         '{-1, 3, 0, 8'h3F, 8'h00, 8'h3F, 1, 1, 0, 4},
         '{-1, 2, 3, 255, 255, 255, 0, 0, 0, 0},
         '{-1, 0, 0, 255, 0, 0, 0, 0, 0, 0},
         '{-1, 0, 0, 0, 0, 255, 1, 0, 0, 0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) begin
         r = probes[i];
         if (r.win >= 0) begin
            wait_idle();
            set_window(win_tab[r.win][0], win_tab[r.win][1], win_tab[r.win][2],
                       win_tab[r.win][3]);
         end
         p.x         = COORD_W'(r.x);
         p.y         = COORD_W'(r.y);
         p.red       = COLOR_W'(r.red);
         p.green     = COLOR_W'(r.green);
         p.blue      = COLOR_W'(r.blue);
         p.frame_end = r.fe;
         send_pixel(p, $urandom_range(0, 3), r.typed, r.hot_bin, r.hot_cnt);
      end

      n_sent = 0;
      while (n_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            // Stray pixels anywhere; a frame end among them is rare.
            repeat ($urandom_range(1, 6)) begin
               p.x         = COORD_W'($urandom);
               p.y         = COORD_W'($urandom);
               p.red       = COLOR_W'($urandom);
               p.green     = COLOR_W'($urandom);
               p.blue      = COLOR_W'($urandom);
               p.frame_end = ($urandom_range(0, 15) == 0);
               send_pixel(p, $urandom_range(0, 3));
               n_sent++;
            end
         end else begin
            fw = $urandom_range(1, 8);
            fh = $urandom_range(1, 6);
            case ($urandom_range(0, 3))
               0:       ox = 0;
               1:       ox = FULL_DIM - fw;
               default: ox = $urandom_range(0, FULL_DIM - fw);
            endcase
            case ($urandom_range(0, 3))
               0:       oy = 0;
               1:       oy = FULL_DIM - fh;
               default: oy = $urandom_range(0, FULL_DIM - fh);
            endcase
            if ($urandom_range(0, 1)) begin
               wait_idle();
               jit_x = $urandom_range(0, fw + 1);
               jit_y = $urandom_range(0, fh + 1);
               case ($urandom_range(0, 5))
                  0: set_window(0, 0, FULL_DIM, FULL_DIM);
                  1: begin
                     if ($urandom_range(0, 1))
                        set_window(ox, oy, 0, $urandom_range(0, FULL_DIM));
                     else
                        set_window(ox, oy, $urandom_range(0, FULL_DIM), 0);
                  end
                  2: set_window($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, FULL_DIM), $urandom_range(0, FULL_DIM));
                  default: set_window(clamp(ox + jit_x - 1, 0, 4095),
                                      clamp(oy + jit_y - 1, 0, 4095),
                                      $urandom_range(0, fw + 2), $urandom_range(0, fh + 2));
               endcase
            end else if (int'(win_w) < 64 && int'(win_h) < 64) begin
               // Keep a small window in play by moving the frame over it.
               jit_x = $urandom_range(0, 4);
               jit_y = $urandom_range(0, 4);
               ox = clamp(int'(win_x) + jit_x - 2, 0, FULL_DIM - fw);
               oy = clamp(int'(win_y) + jit_y - 2, 0, FULL_DIM - fh);
            end
            use_palette = $urandom_range(0, 1);
            no_gaps     = ($urandom_range(0, 3) == 0);
            foreach (palette[k])
               palette[k] = 24'($urandom);
            for (int yy = 0; yy < fh; yy++) begin
               for (int xx = 0; xx < fw; xx++) begin
                  c = use_palette ? palette[$urandom_range(0, 2)] : 24'($urandom);
                  p.x         = COORD_W'(ox + xx);
                  p.y         = COORD_W'(oy + yy);
                  p.red       = c[23:16];
                  p.green     = c[15:8];
                  p.blue      = c[7:0];
                  p.frame_end = (yy == fh - 1) && (xx == fw - 1);
                  send_pixel(p, no_gaps ? 0 : $urandom_range(0, 3));
                  n_sent++;
               end
            end
         end
      end

      wait_idle();
      if (n_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
